@@ hdl/cbrt_pkg.sv @@
// ----------------------------------------------------------------------------
// cbrt_pkg: shared types and constants of the copy-on-write remap table
// widths, reset values, register indexes, request and class codes
// ----------------------------------------------------------------------------
`default_nettype none

package cbrt_pkg;

  // field widths fixed by the stream format
  localparam int BLOCK_W     = 16;
  localparam int SLOT_OUT_W  = 32;
  localparam int REG_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 40;

  // parameter defaults
  localparam int DEF_NUM_BLOCKS = 65536;
  localparam int DEF_SLOT_BITS  = 32;

  // register reset values
  localparam logic [REG_W-1:0] DEF_FIRST_SLOT = 32'd128;
  localparam logic [REG_W-1:0] DEF_SLOT_LIMIT = 32'd65664;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLOT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 2'd1;

  // request kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // read request class
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_SNAP  = 2'd1;
  localparam logic [1:0] MODE_BASE  = 2'd2;
  localparam logic [1:0] MODE_MIXED = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_READ,
    ST_EXEC
  } cbrt_state_t;

endpackage

`default_nettype wire

@@ hdl/cbrt_idx_mod.sv @@
// ----------------------------------------------------------------------------
// cbrt_idx_mod: block index reduction
// two-stage reduction of a block number modulo the table depth
// ----------------------------------------------------------------------------
`default_nettype none

module cbrt_idx_mod
  import cbrt_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
  input  wire logic                          clk,
  input  wire logic [BLOCK_W-1:0]            blk,
  output logic      [$clog2(NUM_BLOCKS)-1:0] idx_r
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int N_W   = IDX_W + 1;
  localparam int PW    = BLOCK_W + 32;
  localparam int RW    = BLOCK_W + N_W;
  localparam longint unsigned RECIP_L = (64'd1 << 32) / NUM_BLOCKS;
  localparam logic [31:0]  RECIP = 32'(RECIP_L);
  localparam logic [N_W-1:0] NB = N_W'(NUM_BLOCKS);

  logic [PW-1:0]      prod;
  logic [BLOCK_W-1:0] q_r;
  logic [BLOCK_W-1:0] blk_q_r;
  logic [RW-1:0]      rem;
  logic [RW-1:0]      rem_fix;

  // quotient estimate, low by at most one
  assign prod = PW'(blk) * PW'(RECIP);

  always_ff @(posedge clk) begin
    q_r     <= prod[PW-1:32];
    blk_q_r <= blk;
  end

  assign rem     = RW'(blk_q_r) - (RW'(q_r) * RW'(NB));
  assign rem_fix = (rem >= RW'(NB)) ? (rem - RW'(NB)) : rem;

  always_ff @(posedge clk) begin
    idx_r <= rem_fix[IDX_W-1:0];
  end

endmodule

`default_nettype wire

@@ hdl/cbrt_map_mem.sv @@
// ----------------------------------------------------------------------------
// cbrt_map_mem: remap store
// single-port-write, registered-read memory of slot numbers per block
// ----------------------------------------------------------------------------
`default_nettype none

module cbrt_map_mem
  import cbrt_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int SLOT_BITS  = DEF_SLOT_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [$clog2(NUM_BLOCKS)-1:0] waddr,
  input  wire logic [SLOT_BITS-1:0]          wdata,
  input  wire logic                          re,
  input  wire logic [$clog2(NUM_BLOCKS)-1:0] raddr,
  output logic      [SLOT_BITS-1:0]          rdata_r
);

  logic [SLOT_BITS-1:0] mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/cow_block_remap_table.sv @@
// ----------------------------------------------------------------------------
// cow_block_remap_table: snapshot copy-on-write block remap table
// allocates store slots on first write and classifies read requests
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole remap store once to zero it, one
// entry a cycle, so in_tready stays low until all NUM_BLOCKS entries are
// cleared; configuration writes are taken during the sweep. Then each request
// runs through a sequence of steps: accept, two-stage index reduction modulo
// NUM_BLOCKS, the synchronous store read, and a decide step that writes back
// a new slot and loads the output register. One request is in flight at a
// time, so a new request is taken only once the previous one has left the
// decide step. The result waits in its own register, so the next request is
// accepted while the previous result is still unclaimed; the decide cycle
// stalls only if that register is still full. Slot numbers come from
// next_slot, loaded from first_slot on reset and on every first_slot write,
// and stop at slot_limit. Configuration must be written only while idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module cow_block_remap_table
  import cbrt_pkg::*;
#(
  parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
  parameter int SLOT_BITS  = DEF_SLOT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] block
  input  wire logic                  in_tuser,   // [0] action
  input  wire logic                  in_tlast,
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // [0] mapped, [32:1] store_slot,
                                                 // [33] allocated, [34] full_res,
                                                 // [36:35] read_mode, rest zero
  // register writes
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [REG_W-1:0]      cfg_wdata
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

  cbrt_state_t state_r, state_nxt;

  logic [IDX_W-1:0]     clr_cnt_r;
  logic [BLOCK_W-1:0]   blk_r;
  logic                 act_r;
  logic                 last_r;
  logic [REG_W-1:0]     slot_limit_r;
  logic [REG_W-1:0]     next_slot_r, next_slot_nxt;
  logic [1:0]           run_mode_r, run_mode_nxt;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // fsm outputs
  logic                 clr_en;
  logic                 rd_en;
  logic                 exec_st;
  logic                 exec_go;

  logic [IDX_W-1:0]     idx_r;
  logic [SLOT_BITS-1:0] cur_slot;
  logic [SLOT_BITS-1:0] new_slot;
  logic [SLOT_BITS-1:0] res_slot;
  logic                 had;
  logic                 alloc;
  logic                 full;
  logic [1:0]           mode_upd;
  logic [1:0]           mode_out;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SLOT_BITS-1:0] mem_wdata;

  // ---------------------------------------------------------------- index unit
  cbrt_idx_mod #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_idx (
    .clk   (clk),
    .blk   (blk_r),
    .idx_r (idx_r)
  );

  // ---------------------------------------------------------------- store
  cbrt_map_mem #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SLOT_BITS  (SLOT_BITS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (rd_en),
    .raddr   (idx_r),
    .rdata_r (cur_slot)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_MOD;
      ST_MOD:   state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EXEC;
      ST_EXEC:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    clr_en    = 1'b0;
    rd_en     = 1'b0;
    exec_st   = 1'b0;
    case (state_r)
      ST_CLEAR: clr_en    = 1'b1;
      ST_IDLE:  in_tready = 1'b1;
      ST_READ:  rd_en     = 1'b1;
      ST_EXEC:  exec_st   = 1'b1;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // decide cycle may finish once the output register is free
  assign exec_go = exec_st && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_en) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      blk_r  <= in_tdata[BLOCK_W-1:0];
      act_r  <= in_tuser;
      last_r <= in_tlast;
    end
  end

  // ---------------------------------------------------------------- decide
  // slot counter value as stored, truncated or zero-extended to the store width
  assign new_slot = SLOT_BITS'({{64{1'b0}}, next_slot_r});
  assign had      = |cur_slot;

  always_comb begin
    alloc    = 1'b0;
    full     = 1'b0;
    res_slot = cur_slot;
    if (act_r == ACT_WRITE && !had) begin
      // zero counter would read back as unmapped, so treat it as exhausted
      if (next_slot_r == '0 || next_slot_r >= slot_limit_r) begin
        full = 1'b1;
      end else begin
        alloc    = 1'b1;
        res_slot = new_slot;
      end
    end
  end

  // running class of the read request
  always_comb begin
    case (run_mode_r)
      MODE_NONE: mode_upd = had ? MODE_SNAP : MODE_BASE;
      MODE_SNAP: mode_upd = had ? MODE_SNAP : MODE_MIXED;
      MODE_BASE: mode_upd = had ? MODE_MIXED : MODE_BASE;
      default:   mode_upd = MODE_MIXED;
    endcase
  end

  always_comb begin
    run_mode_nxt = run_mode_r;
    mode_out     = MODE_NONE;
    if (exec_go && act_r == ACT_READ) begin
      if (last_r) begin
        mode_out     = mode_upd;
        run_mode_nxt = MODE_NONE;
      end else begin
        run_mode_nxt = mode_upd;
      end
    end
  end

  // a first_slot write restarts allocation there
  always_comb begin
    next_slot_nxt = next_slot_r;
    if (cfg_wr_en && cfg_index == CFG_FIRST_SLOT) begin
      next_slot_nxt = cfg_wdata;
    end else if (exec_go && alloc) begin
      next_slot_nxt = next_slot_r + 1'b1;
    end
  end

  // store write: zeroing sweep after reset, else new mappings
  assign mem_we    = clr_en || (exec_go && alloc);
  assign mem_waddr = clr_en ? clr_cnt_r : idx_r;
  assign mem_wdata = clr_en ? '0 : new_slot;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_limit_r <= DEF_SLOT_LIMIT;
      next_slot_r  <= DEF_FIRST_SLOT;
      run_mode_r   <= MODE_NONE;
    end else begin
      next_slot_r <= next_slot_nxt;
      run_mode_r  <= run_mode_nxt;
      if (cfg_wr_en && cfg_index == CFG_SLOT_LIMIT) begin
        slot_limit_r <= cfg_wdata;
      end
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_data_r <= {3'b000, mode_out, full, alloc,
                     SLOT_OUT_W'({{SLOT_OUT_W{1'b0}}, res_slot}), had};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
